[hdl/bcc_pkg.sv]
// shared types and constants for the button click classifier
// no dependencies; used by every module of the block
package bcc_pkg;

    localparam int unsigned CntW   = 16;
    localparam int unsigned TallyW = 3;
    localparam int unsigned CodeW  = 3;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [CntW-1:0]   CntMax   = {CntW{1'b1}};
    localparam logic [TallyW-1:0] TallyMax = 3'd4;

    // register indexes on the config channel
    localparam logic [CfgIdxW-1:0] RegFirstPress = 2'd0;
    localparam logic [CfgIdxW-1:0] RegLongPress  = 2'd1;
    localparam logic [CfgIdxW-1:0] RegRepress    = 2'd2;
    localparam logic [CfgIdxW-1:0] RegWindow     = 2'd3;

    localparam logic [CntW-1:0] FirstPressRst = 16'd20;
    localparam logic [CntW-1:0] LongPressRst  = 16'd1500;
    localparam logic [CntW-1:0] RepressRst    = 16'd2;
    localparam logic [CntW-1:0] WindowRst     = 16'd500;

    typedef enum logic [CodeW-1:0] {
        PH_WAIT     = 3'd0,
        PH_PRESSED  = 3'd1,
        PH_RELEASED = 3'd2,
        PH_LONG     = 3'd3,
        PH_DECIDE   = 3'd4
    } phase_t;

    localparam logic [CodeW-1:0] EvNone   = 3'd0;
    localparam logic [CodeW-1:0] EvSingle = 3'd1;
    localparam logic [CodeW-1:0] EvTriple = 3'd3;
    localparam logic [CodeW-1:0] EvLong   = 3'd4;

    typedef struct packed {
        logic [CntW-1:0] first_press_ticks;
        logic [CntW-1:0] long_press_ticks;
        logic [CntW-1:0] repress_ticks;
        logic [CntW-1:0] click_window_ticks;
    } cfg_t;

    typedef struct packed {
        logic [CodeW-1:0] event_res;
        logic [CodeW-1:0] phase;
    } result_t;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        sat_inc = (v == CntMax) ? v : v + 1'b1;
    endfunction

endpackage

[hdl/bcc_cfg.sv]
// threshold registers written over the config channel
// depends on bcc_pkg
module bcc_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bcc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [bcc_pkg::CntW-1:0]     cfg_wdata,
    output bcc_pkg::cfg_t                cfg
);

    bcc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_press_ticks  <= bcc_pkg::FirstPressRst;
            cfg_reg.long_press_ticks   <= bcc_pkg::LongPressRst;
            cfg_reg.repress_ticks      <= bcc_pkg::RepressRst;
            cfg_reg.click_window_ticks <= bcc_pkg::WindowRst;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bcc_pkg::RegFirstPress: cfg_reg.first_press_ticks  <= cfg_wdata;
                bcc_pkg::RegLongPress:  cfg_reg.long_press_ticks   <= cfg_wdata;
                bcc_pkg::RegRepress:    cfg_reg.repress_ticks      <= cfg_wdata;
                bcc_pkg::RegWindow:     cfg_reg.click_window_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

[hdl/bcc_core.sv]
// classifier state and its one-tick update
// depends on bcc_pkg
module bcc_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              down,
    input  bcc_pkg::cfg_t     cfg,
    output bcc_pkg::result_t  res
);

    bcc_pkg::phase_t               phase_reg, phase_next;
    logic [bcc_pkg::CntW-1:0]      debounce_reg, debounce_next;
    logic [bcc_pkg::CntW-1:0]      window_reg, window_next;
    logic [bcc_pkg::TallyW-1:0]    tally_reg, tally_next;
    logic [bcc_pkg::CodeW-1:0]     event_res;
    logic [bcc_pkg::CntW-1:0]      deb_inc, win_inc;

    assign deb_inc = bcc_pkg::sat_inc(debounce_reg);
    assign win_inc = bcc_pkg::sat_inc(window_reg);

    always_comb begin
        phase_next    = phase_reg;
        debounce_next = debounce_reg;
        window_next   = window_reg;
        tally_next    = tally_reg;
        event_res     = bcc_pkg::EvNone;
        unique case (phase_reg)
            bcc_pkg::PH_PRESSED: begin
                debounce_next = deb_inc;
                window_next   = win_inc;
                if (!down) begin
                    if (tally_reg < bcc_pkg::TallyMax) begin
                        tally_next = tally_reg + 1'b1;
                    end
                    debounce_next = '0;
                    phase_next    = bcc_pkg::PH_RELEASED;
                end else if (deb_inc >= cfg.long_press_ticks) begin
                    debounce_next = '0;
                    phase_next    = bcc_pkg::PH_LONG;
                    event_res     = bcc_pkg::EvLong;
                end
            end
            bcc_pkg::PH_RELEASED: begin
                if (win_inc <= cfg.click_window_ticks) begin
                    window_next = win_inc;
                    if (down) begin
                        if (deb_inc >= cfg.repress_ticks) begin
                            debounce_next = '0;
                            phase_next    = bcc_pkg::PH_PRESSED;
                        end else begin
                            debounce_next = deb_inc;
                        end
                    end else begin
                        debounce_next = '0;
                    end
                end else begin
                    window_next = '0;
                    phase_next  = bcc_pkg::PH_DECIDE;
                end
            end
            bcc_pkg::PH_LONG: begin
                if (!down) begin
                    phase_next = bcc_pkg::PH_WAIT;
                end
            end
            bcc_pkg::PH_DECIDE: begin
                if (tally_reg >= bcc_pkg::EvSingle && tally_reg <= bcc_pkg::EvTriple) begin
                    event_res = tally_reg;
                end
                tally_next = '0;
                phase_next = bcc_pkg::PH_WAIT;
            end
            default: begin
                // waiting, and any stray code behaves the same
                phase_next = bcc_pkg::PH_WAIT;
                if (down) begin
                    if (deb_inc >= cfg.first_press_ticks) begin
                        debounce_next = '0;
                        phase_next    = bcc_pkg::PH_PRESSED;
                    end else begin
                        debounce_next = deb_inc;
                    end
                end else begin
                    debounce_next = '0;
                    window_next   = '0;
                end
            end
        endcase
    end

    assign res.event_res = event_res;
    assign res.phase     = phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= bcc_pkg::PH_WAIT;
            debounce_reg <= '0;
            window_reg   <= '0;
            tally_reg    <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            debounce_reg <= debounce_next;
            window_reg   <= window_next;
            tally_reg    <= tally_next;
        end
    end

endmodule

[hdl/button_click_classifier_top.sv]
// channel  | dir | beat content
// s_       | in  | tdata[0] key_down, [7:1] zero
// m_       | out | tdata[2:0] event_res, [5:3] phase, [7:6] zero
// cfg_     | in  | cfg_index register, cfg_wdata 16-bit value
//
// one tick per beat, one result beat per input beat; each beat passes through the input
// register, then the state update into the output register
// synchronous active-low reset returns thresholds to defaults, phase to waiting
// a stalled output holds its beat; input is still taken while the input
// register is empty or moving on
//
// top level: input register, classifier core, config registers, output register
// depends on bcc_pkg, bcc_cfg, bcc_core
module button_click_classifier_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,    // [0] key_down
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,    // [2:0] event_res, [5:3] phase
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bcc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [bcc_pkg::CntW-1:0]     cfg_wdata
);

    logic             in_valid_reg;
    logic             in_down_reg;
    logic             m_valid_reg;
    bcc_pkg::result_t m_res_reg;
    logic             out_free;
    logic             step;
    bcc_pkg::cfg_t    cfg;
    bcc_pkg::result_t res;

    assign out_free = !m_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_down_reg <= s_tdata[0];
        end
    end

    bcc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bcc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .down    (in_down_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_res_reg.phase, m_res_reg.event_res};

endmodule

[hdl/bcc_checker.sv]
// port-level checks for the button click classifier, bound to the top level
// depends on bcc_pkg
module bcc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // a held beat keeps its content
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // long press leaves the block in long held
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == bcc_pkg::EvLong |->
        m_tdata[5:3] == bcc_pkg::PH_LONG)
        else $error("long press event without long held phase");

    // click events come out of deciding, which always returns to waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != bcc_pkg::EvNone && m_tdata[2:0] != bcc_pkg::EvLong |->
        m_tdata[5:3] == bcc_pkg::PH_WAIT)
        else $error("click event outside the deciding step");

    // nothing is offered right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/bcc_click_checker.sv]
`timescale 1ns / 1ps
// result checker for the button click classifier: predicts every output beat from the
// accepted tick and config beats and compares it field by field; needs bcc_pkg only
module bcc_click_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,     // [0] key_down
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [7:0]                  m_tdata,     // [2:0] event_res, [5:3] phase
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [bcc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [bcc_pkg::CntW-1:0]    cfg_wdata,
    output int unsigned                 mismatch_count,
    output int unsigned                 results_due
);

    bcc_pkg::cfg_t              thresholds;
    bcc_pkg::phase_t            phase_q;
    logic [bcc_pkg::CntW-1:0]   debounce_q;
    logic [bcc_pkg::CntW-1:0]   window_q;
    logic [bcc_pkg::TallyW-1:0] tally_q;
    bcc_pkg::result_t           due_results[$];

    function automatic logic [bcc_pkg::CntW-1:0] sat_bump(input logic [bcc_pkg::CntW-1:0] v);
        return (v == bcc_pkg::CntMax) ? v : v + 1'b1;
    endfunction

    // advance the classifier by one tick, return the beat it produces
    function automatic bcc_pkg::result_t classify_tick(input logic down);
        logic [bcc_pkg::CodeW-1:0] ev;
        bcc_pkg::result_t          r;
        ev = bcc_pkg::EvNone;
        case (phase_q)
            bcc_pkg::PH_PRESSED: begin
                debounce_q = sat_bump(debounce_q);
                window_q   = sat_bump(window_q);
                if (!down) begin
                    if (tally_q < bcc_pkg::TallyMax) tally_q = tally_q + 1'b1;
                    debounce_q = '0;
                    phase_q    = bcc_pkg::PH_RELEASED;
                end else if (debounce_q >= thresholds.long_press_ticks) begin
                    debounce_q = '0;
                    phase_q    = bcc_pkg::PH_LONG;
                    ev         = bcc_pkg::EvLong;
                end
            end
            bcc_pkg::PH_RELEASED: begin
                window_q = sat_bump(window_q);
                if (window_q <= thresholds.click_window_ticks) begin
                    if (down) begin
                        debounce_q = sat_bump(debounce_q);
                        if (debounce_q >= thresholds.repress_ticks) begin
                            debounce_q = '0;
                            phase_q    = bcc_pkg::PH_PRESSED;
                        end
                    end else begin
                        debounce_q = '0;
                    end
                end else begin
                    window_q = '0;
                    phase_q  = bcc_pkg::PH_DECIDE;
                end
            end
            bcc_pkg::PH_LONG: begin
                if (!down) phase_q = bcc_pkg::PH_WAIT;
            end
            bcc_pkg::PH_DECIDE: begin
                // tally of one to three maps straight onto the click event code
                if (tally_q >= bcc_pkg::EvSingle && tally_q <= bcc_pkg::EvTriple) ev = tally_q;
                tally_q = '0;
                phase_q = bcc_pkg::PH_WAIT;
            end
            default: begin
                phase_q = bcc_pkg::PH_WAIT;
                if (down) begin
                    debounce_q = sat_bump(debounce_q);
                    if (debounce_q >= thresholds.first_press_ticks) begin
                        debounce_q = '0;
                        phase_q    = bcc_pkg::PH_PRESSED;
                    end
                end else begin
                    debounce_q = '0;
                    window_q   = '0;
                end
            end
        endcase
        r.event_res = ev;
        r.phase     = phase_q;
        return r;
    endfunction

    always @(posedge aclk) begin
        bcc_pkg::result_t want;
        if (!aresetn) begin
            thresholds.first_press_ticks  = bcc_pkg::FirstPressRst;
            thresholds.long_press_ticks   = bcc_pkg::LongPressRst;
            thresholds.repress_ticks      = bcc_pkg::RepressRst;
            thresholds.click_window_ticks = bcc_pkg::WindowRst;
            phase_q        = bcc_pkg::PH_WAIT;
            debounce_q     = '0;
            window_q       = '0;
            tally_q        = '0;
            mismatch_count = 0;
            due_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bcc_pkg::RegFirstPress: thresholds.first_press_ticks  = cfg_wdata;
                    bcc_pkg::RegLongPress:  thresholds.long_press_ticks   = cfg_wdata;
                    bcc_pkg::RegRepress:    thresholds.repress_ticks      = cfg_wdata;
                    bcc_pkg::RegWindow:     thresholds.click_window_ticks = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    want = due_results.pop_front();
                    if (m_tdata[2:0] !== want.event_res) begin
                        mismatch_count++;
                        $display("%0t: event_res mismatch, expected %0d, got %0d",
                                 $time, want.event_res, m_tdata[2:0]);
                    end
                    if (m_tdata[5:3] !== want.phase) begin
                        mismatch_count++;
                        $display("%0t: phase mismatch, expected %0d, got %0d",
                                 $time, want.phase, m_tdata[5:3]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(classify_tick(s_tdata[0]));
        end
        results_due = due_results.size();
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// top of the button click classifier testbench: clock, reset, tick and config stimulus,
// ready stalls, watchdog and verdict; needs bcc_pkg, button_click_classifier_top, bcc_click_checker
module tb_top;

    localparam int unsigned StallLimit  = 2000;
    localparam int unsigned TicksPerSet = 150;
    localparam int unsigned NumPlans    = 8;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [7:0]                  s_tdata;     // [0] key_down
    logic                        m_tvalid;
    logic                        m_tready;
    logic [7:0]                  m_tdata;     // [2:0] event_res, [5:3] phase
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [bcc_pkg::CfgIdxW-1:0] cfg_index;
    logic [bcc_pkg::CntW-1:0]    cfg_wdata;

    int unsigned   mismatch_count;
    int unsigned   results_due;
    int unsigned   idle_cycles;
    int unsigned   ticks_sent;
    bit            paced;
    bcc_pkg::cfg_t plans [NumPlans];

    button_click_classifier_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    bcc_click_checker click_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // one beat per tick; valid stays up across back-to-back beats
    task automatic send_tick(input logic lvl);
        int unsigned gap;
        gap = paced ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, lvl};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
    endtask

    task automatic send_ticks(input logic lvl, input int unsigned n);
        for (int unsigned i = 0; i < n; i++) send_tick(lvl);
    endtask

    task automatic put_reg(input logic [bcc_pkg::CfgIdxW-1:0] idx,
                           input logic [bcc_pkg::CntW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // drain every outstanding result, then load all four thresholds
    task automatic apply_setting(input bcc_pkg::cfg_t c);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (results_due == 0);
        repeat (2) @(posedge aclk);
        put_reg(bcc_pkg::RegFirstPress, c.first_press_ticks);
        put_reg(bcc_pkg::RegLongPress,  c.long_press_ticks);
        put_reg(bcc_pkg::RegRepress,    c.repress_ticks);
        put_reg(bcc_pkg::RegWindow,     c.click_window_ticks);
        cfg_valid <= 1'b0;
    endtask

    // a run of presses inside one window, sometimes cut short of the debounce
    task automatic play_clicks(input bcc_pkg::cfg_t c);
        int unsigned n;
        int unsigned thr;
        int unsigned len;
        n = $urandom_range(1, 5);
        for (int unsigned k = 0; k < n; k++) begin
            thr = (k == 0) ? c.first_press_ticks : c.repress_ticks;
            if ($urandom_range(0, 5) == 0)
                len = $urandom_range(1, thr + 1);
            else
                len = thr + $urandom_range(1, 3);
            send_ticks(1'b1, len);
            send_ticks(1'b0, $urandom_range(1, 4));
        end
        send_ticks(1'b0, c.click_window_ticks + 3);
    endtask

    // long hold, optionally a new press right after release to carry the window count
    task automatic play_long_hold(input bcc_pkg::cfg_t c);
        send_ticks(1'b1, c.first_press_ticks + c.long_press_ticks + $urandom_range(1, 4));
        send_ticks(1'b0, 1);
        if ($urandom_range(0, 1) == 1) begin
            send_ticks(1'b1, c.first_press_ticks + $urandom_range(1, 3));
            send_ticks(1'b0, $urandom_range(1, 3));
        end
    endtask

    task automatic play_noise(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) send_tick(1'($urandom_range(0, 1)));
    endtask

    // output side stalls independently of the input side
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = paced ? $urandom_range(0, 8) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("button_click_classifier_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned kind;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        aresetn     = 1'b0;
        ticks_sent  = 0;
        paced       = 1'b0;

        plans[0] = '{16'd1, 16'd4, 16'd1, 16'd10};
        plans[1] = '{16'd0, 16'd0, 16'd0, 16'd0};
        plans[2] = '{16'd3, 16'd8, 16'd2, 16'd20};
        plans[3] = '{16'd2, 16'd20, 16'd3, 16'd30};
        plans[4] = '{16'd1, 16'd1, 16'd1, 16'd1};
        plans[5] = '{16'd5, 16'd12, 16'd0, 16'd6};
        for (int i = 6; i < NumPlans; i++) begin
            plans[i].first_press_ticks  = 16'($urandom_range(0, 6));
            plans[i].long_press_ticks   = 16'($urandom_range(0, 12));
            plans[i].repress_ticks      = 16'($urandom_range(0, 4));
            plans[i].click_window_ticks = 16'($urandom_range(0, 40));
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // a few ticks under the reset thresholds, ending idle in waiting
        send_ticks(1'b1, 3);
        send_ticks(1'b0, 2);

        // top-of-range long-press and window thresholds, hold stays short of them
        apply_setting('{16'd1, bcc_pkg::CntMax, 16'd1, bcc_pkg::CntMax});
        send_ticks(1'b1, 40);
        send_ticks(1'b0, 1);
        send_ticks(1'b1, 2);
        send_ticks(1'b0, 4);
        // closing the window with a zero window length
        apply_setting('{16'd1, bcc_pkg::CntMax, 16'd1, 16'd0});
        send_ticks(1'b0, 3);

        // single, double, long press with moderate thresholds
        paced = 1'b1;
        apply_setting('{16'd2, 16'd4, 16'd1, 16'd3});
        send_ticks(1'b1, 3);
        send_ticks(1'b0, 6);
        send_ticks(1'b1, 3);
        send_ticks(1'b0, 1);
        send_ticks(1'b1, 2);
        send_ticks(1'b0, 6);
        send_ticks(1'b1, 7);
        send_ticks(1'b0, 1);

        // max debounce thresholds with zero long and window, noise only
        apply_setting('{bcc_pkg::CntMax, 16'd0, bcc_pkg::CntMax, 16'd0});
        play_noise(30);

        for (int p = 0; p < NumPlans; p++) begin
            apply_setting(plans[p]);
            ticks_sent = 0;
            while (ticks_sent < TicksPerSet) begin
                paced = ($urandom_range(0, 3) != 0);
                kind  = $urandom_range(0, 9);
                if (kind <= 5)
                    play_clicks(plans[p]);
                else if (kind <= 7)
                    play_long_hold(plans[p]);
                else
                    play_noise($urandom_range(1, 12));
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (results_due == 0);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("button_click_classifier_top regression: pass");
        else
            $display("button_click_classifier_top regression: fail");
        $finish;
    end

endmodule

[sim.f]
hdl/bcc_pkg.sv
hdl/bcc_cfg.sv
hdl/bcc_core.sv
hdl/button_click_classifier_top.sv
hdl/bcc_checker.sv
dv/bcc_click_checker.sv
dv/tb_top.sv
